/* rtl/box_muller_gaussian_defines.svh */
// Assertion macros for the Gaussian generator top level.
`ifndef BOX_MULLER_GAUSSIAN_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define BMG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define BMG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bmg_pkg.sv */
// Types, constants and divisor tables of the Gaussian generator.
`timescale 1ns / 1ps
package bmg_pkg;

    localparam int UNIFORM_BITS = 32;
    localparam logic [31:0] UNIFORM_MASK = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
    // phase alignment of the angle code to Q.32 turns
    localparam int PHASE_UP   = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
    localparam int PHASE_DOWN = (UNIFORM_BITS > 32) ? UNIFORM_BITS - 32 : 0;
    localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    localparam int LOG_STEPS  = 32;
    localparam int SQRT_STEPS = 32;
    localparam int TERM_CELLS = 6;
    localparam logic [2:0] LAST_SIN_TERM = 3'd4;

    localparam logic CFG_MEAN     = 1'b0;
    localparam logic CFG_VARIANCE = 1'b1;

    typedef struct packed {
        logic        vld;
        logic [2:0]  q;
        logic [29:0] ang;
        logic [5:0]  k;
        logic [31:0] root_s;
        logic [27:0] root_r;
    } t_ctx;

    typedef struct packed {
        logic [31:0] m;
        logic [31:0] f;
    } t_log;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [31:0] x2;
        logic [32:0] ts;
        logic [32:0] tc;
        logic [32:0] acc_s;
        logic [32:0] acc_c;
    } t_trig;

    // cos term n divides by (2n-1)(2n); cell index is n-1
    function automatic logic [7:0] cos_div(input logic [2:0] idx);
        case (idx)
            3'd0: cos_div = 8'd2;
            3'd1: cos_div = 8'd12;
            3'd2: cos_div = 8'd30;
            3'd3: cos_div = 8'd56;
            3'd4: cos_div = 8'd90;
            3'd5: cos_div = 8'd132;
            default: cos_div = 8'd2;
        endcase
    endfunction

    // floor(2^32 / cos_div)
    function automatic logic [31:0] cos_rcp(input logic [2:0] idx);
        case (idx)
            3'd0: cos_rcp = 32'd2147483648;
            3'd1: cos_rcp = 32'd357913941;
            3'd2: cos_rcp = 32'd143165576;
            3'd3: cos_rcp = 32'd76695844;
            3'd4: cos_rcp = 32'd47721858;
            3'd5: cos_rcp = 32'd32537631;
            default: cos_rcp = 32'd2147483648;
        endcase
    endfunction

    // sin term n divides by (2n)(2n+1)
    function automatic logic [7:0] sin_div(input logic [2:0] idx);
        case (idx)
            3'd0: sin_div = 8'd6;
            3'd1: sin_div = 8'd20;
            3'd2: sin_div = 8'd42;
            3'd3: sin_div = 8'd72;
            3'd4: sin_div = 8'd110;
            default: sin_div = 8'd6;
        endcase
    endfunction

    function automatic logic [31:0] sin_rcp(input logic [2:0] idx);
        case (idx)
            3'd0: sin_rcp = 32'd715827882;
            3'd1: sin_rcp = 32'd214748364;
            3'd2: sin_rcp = 32'd102261126;
            3'd3: sin_rcp = 32'd59652323;
            3'd4: sin_rcp = 32'd39045157;
            default: sin_rcp = 32'd715827882;
        endcase
    endfunction

endpackage

/* rtl/box_muller_gaussian.sv */
// Top level of the Box-Muller Gaussian generator, signed Q16.16 output.
// Each accepted item (two 32-bit uniform codes) yields two samples on the
// result channel: R*cos(theta) first, then R*sin(theta) with o_last high.
// The single result port moves one sample per cycle while i_ready is high
// and sets the item rate; the compute pipeline itself can advance in every
// cycle the output register allows. Between input accept and the first
// sample in the output register lie the following: one entry stage,
// a row of 32 log2 squaring cells (with a 32-cell square root row for the
// variance scale beside it), one stage forming -2 ln u1, 32 square root
// cells for the radius, two angle stages, six Taylor term cells of three
// stages each, and two scaling stages. Input ready drops while the cosine
// sample waits in the output register; the whole pipeline holds on a stall.
// A first_uniform of zero is treated as one. Samples that leave the int32
// range are clipped and flagged on o_saturated. Configuration writes take
// effect on items accepted afterwards and must happen while the block is idle.
`timescale 1ns / 1ps
`include "box_muller_gaussian_defines.svh"
module box_muller_gaussian (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // input item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_first_uniform,
    input  logic [31:0] i_second_uniform,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_sample,
    output logic        o_last,
    output logic        o_saturated
);

    // config registers
    logic [31:0] r_mean;
    logic [31:0] r_var;

    // global advance: output buffer empty or its last sample leaving
    logic w_en;

    // entry stage
    logic [31:0]    w_c1;
    logic [4:0]     w_e;
    logic [31:0]    w_m;
    logic [31:0]    w_p;
    bmg_pkg::t_ctx  n_in_ctx;
    bmg_pkg::t_ctx  r_in_ctx;
    bmg_pkg::t_log  r_in_log;
    bmg_pkg::t_sqrt r_in_ssq;

    bmg_pkg::t_ctx  w_lctx [0:bmg_pkg::LOG_STEPS];
    bmg_pkg::t_log  w_llog [0:bmg_pkg::LOG_STEPS];
    bmg_pkg::t_sqrt w_ssq  [0:bmg_pkg::SQRT_STEPS];

    // -2 ln u1 stage
    logic [37:0]    w_l;
    logic [39:0]    w_xa;
    logic [63:0]    w_xb;
    logic [39:0]    w_x;
    bmg_pkg::t_ctx  n_x_ctx;
    bmg_pkg::t_ctx  r_x_ctx;
    bmg_pkg::t_sqrt r_x_sq;

    // radius root row, context rides alongside
    bmg_pkg::t_sqrt w_rsq  [0:bmg_pkg::SQRT_STEPS];
    bmg_pkg::t_ctx  r_rctx [0:bmg_pkg::SQRT_STEPS-1];

    // angle stages
    logic [61:0]    w_ax;
    logic [63:0]    w_xx;
    bmg_pkg::t_ctx  n_t0_ctx;
    bmg_pkg::t_ctx  r_t0_ctx;
    logic [31:0]    r_t0_x;
    bmg_pkg::t_ctx  r_t1_ctx;
    bmg_pkg::t_trig r_t1_trig;

    bmg_pkg::t_ctx  w_tctx [0:bmg_pkg::TERM_CELLS];
    bmg_pkg::t_trig w_trig [0:bmg_pkg::TERM_CELLS];

    // scaling stages
    logic           w_swap;
    logic [32:0]    w_cv, w_sv;
    logic [60:0]    w_gpc, w_gps;
    logic           r_f1_vld;
    logic [28:0]    r_f1_gc, r_f1_gs;
    logic           r_f1_cneg, r_f1_sneg;
    logic [31:0]    r_f1_s;
    logic [60:0]    w_mpc, w_mps;
    logic           r_f2_vld;
    logic [28:0]    r_f2_mc, r_f2_ms;
    logic           r_f2_cneg, r_f2_sneg;
    logic [32:0]    w_oc, w_os;

    // output buffer holds both samples of one item
    logic           r_ovld;
    logic           r_olast;
    logic [31:0]    r_samp0, r_samp1;
    logic           r_sat0, r_sat1;

    // add offset and clip; returns {saturated, sample}
    function automatic logic [32:0] offset_sat(input logic [31:0] mean,
                                               input logic [28:0] mag,
                                               input logic neg);
        logic signed [33:0] v;
        logic [32:0] res;
        v = neg ? $signed({{2{mean[31]}}, mean}) - $signed({5'b0, mag})
                : $signed({{2{mean[31]}}, mean}) + $signed({5'b0, mag});
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            res = {1'b0, v[31:0]};
        end else begin
            res = {1'b1, v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return res;
    endfunction

    assign w_en    = !r_ovld || (r_olast && i_ready);
    assign o_ready = w_en;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= 32'd0;
            r_var  <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmg_pkg::CFG_MEAN:     r_mean <= i_cfg_data;
                bmg_pkg::CFG_VARIANCE: r_var  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- entry: normalize u1, fold the phase ----------------
    always_comb begin
        w_c1 = i_first_uniform & bmg_pkg::UNIFORM_MASK;
        if (w_c1 == 32'd0) begin
            w_c1 = 32'd1;
        end
        w_e = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (w_c1[i]) begin
                w_e = 5'(i);
            end
        end
        w_m = w_c1 << (5'd31 - w_e);
        // align the angle code to Q.32 turns
        w_p = 32'((64'(i_second_uniform & bmg_pkg::UNIFORM_MASK) << bmg_pkg::PHASE_UP)
                  >> bmg_pkg::PHASE_DOWN);
        n_in_ctx.vld    = i_valid;
        n_in_ctx.q      = w_p[31:29];
        n_in_ctx.ang    = w_p[29] ? 30'h2000_0000 - {1'b0, w_p[28:0]} : {1'b0, w_p[28:0]};
        n_in_ctx.k      = 6'(bmg_pkg::UNIFORM_BITS) - {1'b0, w_e};
        n_in_ctx.root_s = 32'd0;
        n_in_ctx.root_r = 28'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctx.vld <= 1'b0;
        end else if (w_en) begin
            r_in_ctx <= n_in_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_log.m    <= w_m;
            r_in_log.f    <= 32'd0;
            r_in_ssq.rad  <= {r_var, 32'd0};
            r_in_ssq.rem  <= 34'd0;
            r_in_ssq.root <= 32'd0;
        end
    end

    // ---------------- log2 row and variance root row ----------------
    assign w_lctx[0] = r_in_ctx;
    assign w_llog[0] = r_in_log;
    assign w_ssq[0]  = r_in_ssq;

    for (genvar g = 0; g < bmg_pkg::LOG_STEPS; g++) begin : g_log
        bmg_log_cell u_log (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctx   (w_lctx[g]),
            .i_log   (w_llog[g]),
            .o_ctx   (w_lctx[g+1]),
            .o_log   (w_llog[g+1])
        );
        bmg_sqrt_cell u_ssq (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sq  (w_ssq[g]),
            .o_sq  (w_ssq[g+1])
        );
    end

    // ---------------- X = -2 ln u1, Q.32 ----------------
    always_comb begin
        w_l  = {w_lctx[bmg_pkg::LOG_STEPS].k, 32'd0}
             - {6'd0, w_llog[bmg_pkg::LOG_STEPS].f};
        w_xa = 40'(w_l[37:32]) * 40'(bmg_pkg::TWO_LN2_Q30) * 40'd4;
        w_xb = 64'(w_l[31:0]) * 64'(bmg_pkg::TWO_LN2_Q30);
        w_x  = w_xa + 40'(w_xb[63:30]);
        n_x_ctx        = w_lctx[bmg_pkg::LOG_STEPS];
        n_x_ctx.root_s = w_ssq[bmg_pkg::SQRT_STEPS].root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_ctx.vld <= 1'b0;
        end else if (w_en) begin
            r_x_ctx <= n_x_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_sq.rad  <= {8'd0, w_x, 16'd0};
            r_x_sq.rem  <= 34'd0;
            r_x_sq.root <= 32'd0;
        end
    end

    // ---------------- radius root row ----------------
    assign w_rsq[0] = r_x_sq;

    for (genvar g = 0; g < bmg_pkg::SQRT_STEPS; g++) begin : g_rsq
        bmg_sqrt_cell u_rsq (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sq  (w_rsq[g]),
            .o_sq  (w_rsq[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bmg_pkg::SQRT_STEPS; i++) begin
                r_rctx[i].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_rctx[0] <= r_x_ctx;
            for (int i = 1; i < bmg_pkg::SQRT_STEPS; i++) begin
                r_rctx[i] <= r_rctx[i-1];
            end
        end
    end

    // ---------------- angle: x in Q.32 radians, then x^2 ----------------
    always_comb begin
        w_ax = 62'(r_rctx[bmg_pkg::SQRT_STEPS-1].ang) * 62'(bmg_pkg::PI_Q30);
        w_xx = 64'(r_t0_x) * 64'(r_t0_x);
        n_t0_ctx        = r_rctx[bmg_pkg::SQRT_STEPS-1];
        n_t0_ctx.root_r = w_rsq[bmg_pkg::SQRT_STEPS].root[27:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_ctx.vld <= 1'b0;
            r_t1_ctx.vld <= 1'b0;
        end else if (w_en) begin
            r_t0_ctx <= n_t0_ctx;
            r_t1_ctx <= r_t0_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0_x          <= w_ax[60:29];
            r_t1_trig.x2    <= w_xx[63:32];
            r_t1_trig.ts    <= {1'b0, r_t0_x};
            r_t1_trig.acc_s <= {1'b0, r_t0_x};
            r_t1_trig.tc    <= bmg_pkg::ONE_Q32;
            r_t1_trig.acc_c <= bmg_pkg::ONE_Q32;
        end
    end

    // ---------------- Taylor term row ----------------
    assign w_tctx[0] = r_t1_ctx;
    assign w_trig[0] = r_t1_trig;

    for (genvar g = 0; g < bmg_pkg::TERM_CELLS; g++) begin : g_term
        bmg_term_cell u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (3'(g)),
            .i_ctx   (w_tctx[g]),
            .i_trig  (w_trig[g]),
            .o_ctx   (w_tctx[g+1]),
            .o_trig  (w_trig[g+1])
        );
    end

    // ---------------- octant map and scaling ----------------
    always_comb begin
        // octants 1, 2, 5, 6 swap sin and cos
        w_swap = w_tctx[bmg_pkg::TERM_CELLS].q[0] ^ w_tctx[bmg_pkg::TERM_CELLS].q[1];
        w_cv   = w_swap ? w_trig[bmg_pkg::TERM_CELLS].acc_s : w_trig[bmg_pkg::TERM_CELLS].acc_c;
        w_sv   = w_swap ? w_trig[bmg_pkg::TERM_CELLS].acc_c : w_trig[bmg_pkg::TERM_CELLS].acc_s;
        w_gpc  = 61'(w_tctx[bmg_pkg::TERM_CELLS].root_r) * 61'(w_cv);
        w_gps  = 61'(w_tctx[bmg_pkg::TERM_CELLS].root_r) * 61'(w_sv);
        // round half up in magnitude
        w_mpc  = 61'(r_f1_gc) * 61'(r_f1_s) + 61'h8000_0000;
        w_mps  = 61'(r_f1_gs) * 61'(r_f1_s) + 61'h8000_0000;
        w_oc   = offset_sat(r_mean, r_f2_mc, r_f2_cneg);
        w_os   = offset_sat(r_mean, r_f2_ms, r_f2_sneg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= w_tctx[bmg_pkg::TERM_CELLS].vld;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_gc   <= w_gpc[60:32];
            r_f1_gs   <= w_gps[60:32];
            r_f1_cneg <= w_tctx[bmg_pkg::TERM_CELLS].q[1] ^ w_tctx[bmg_pkg::TERM_CELLS].q[2];
            r_f1_sneg <= w_tctx[bmg_pkg::TERM_CELLS].q[2];
            r_f1_s    <= w_tctx[bmg_pkg::TERM_CELLS].root_s;
            r_f2_mc   <= w_mpc[60:32];
            r_f2_ms   <= w_mps[60:32];
            r_f2_cneg <= r_f1_cneg;
            r_f2_sneg <= r_f1_sneg;
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld  <= 1'b0;
            r_olast <= 1'b0;
        end else if (w_en) begin
            r_ovld  <= r_f2_vld;
            r_olast <= 1'b0;
        end else if (r_ovld && i_ready) begin
            r_olast <= 1'b1;    // cosine item taken, sine next
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_samp0 <= w_oc[31:0];
            r_sat0  <= w_oc[32];
            r_samp1 <= w_os[31:0];
            r_sat1  <= w_os[32];
        end
    end

    assign o_valid     = r_ovld;
    assign o_last      = r_olast;
    assign o_sample    = r_olast ? r_samp1 : r_samp0;
    assign o_saturated = r_olast ? r_sat1 : r_sat0;

    // ---------------- assertions ----------------
    `BMG_ASSERT_NXT(a_sine_follows, r_ovld && !r_olast && i_ready, r_ovld && r_olast, "sine item did not follow cosine")
    `BMG_ASSERT_IMP(a_stall_on_cos, r_ovld && !r_olast, !w_en, "pipeline advanced over a waiting cosine item")
    `BMG_ASSERT_NXT(a_drain_empty, r_ovld && r_olast && i_ready && !r_f2_vld, !r_ovld, "output buffer kept a delivered pair")

endmodule

/* rtl/bmg_log_cell.sv */
// One squaring step of the log2 fraction chain.
`timescale 1ns / 1ps
module bmg_log_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  bmg_pkg::t_ctx i_ctx,
    input  bmg_pkg::t_log i_log,
    output bmg_pkg::t_ctx o_ctx,
    output bmg_pkg::t_log o_log
);

    logic [63:0]   w_sq;
    logic [32:0]   w_t;
    bmg_pkg::t_log n_log;
    bmg_pkg::t_log r_log;
    bmg_pkg::t_ctx r_ctx;

    always_comb begin
        w_sq = 64'(i_log.m) * 64'(i_log.m);
        w_t  = w_sq[63:31];
        n_log.m = w_t[32] ? w_t[32:1] : w_t[31:0];
        n_log.f = {i_log.f[30:0], w_t[32]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.vld <= 1'b0;
        end else if (i_en) begin
            r_ctx <= i_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_log <= n_log;
        end
    end

    assign o_ctx = r_ctx;
    assign o_log = r_log;

endmodule

/* rtl/bmg_sqrt_cell.sv */
// One result bit of the digit-by-digit integer square root chain.
`timescale 1ns / 1ps
module bmg_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  bmg_pkg::t_sqrt i_sq,
    output bmg_pkg::t_sqrt o_sq
);

    logic [34:0]    w_cur;
    logic [34:0]    w_trial;
    bmg_pkg::t_sqrt n_sq;
    bmg_pkg::t_sqrt r_sq;

    always_comb begin
        w_cur   = {i_sq.rem[32:0], i_sq.rad[63:62]};
        w_trial = {1'b0, i_sq.root, 2'b01};
        n_sq.rad = {i_sq.rad[61:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_sq.rem  = 34'(w_cur - w_trial);
            n_sq.root = {i_sq.root[30:0], 1'b1};
        end else begin
            n_sq.rem  = w_cur[33:0];
            n_sq.root = {i_sq.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

/* rtl/bmg_term_cell.sv */
// One Taylor term of sin and cos: multiply, divide by constant, accumulate.
`timescale 1ns / 1ps
module bmg_term_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [2:0]     i_idx,
    input  bmg_pkg::t_ctx  i_ctx,
    input  bmg_pkg::t_trig i_trig,
    output bmg_pkg::t_ctx  o_ctx,
    output bmg_pkg::t_trig o_trig
);

    logic [7:0]     w_ds, w_dc;
    logic [31:0]    w_ms, w_mc;
    logic           w_sin_on, w_sub;
    logic [64:0]    w_ps, w_pc;
    logic [63:0]    w_rs, w_rc;
    logic [31:0]    w_qds, w_qdc;
    logic [31:0]    w_rem_s, w_rem_c;
    logic [31:0]    w_qs, w_qc;
    bmg_pkg::t_trig n_trig;

    logic [31:0]    r1_ns, r1_nc;
    bmg_pkg::t_trig r1_trig;
    bmg_pkg::t_ctx  r1_ctx;
    logic [31:0]    r2_q0s, r2_q0c, r2_ns, r2_nc;
    bmg_pkg::t_trig r2_trig;
    bmg_pkg::t_ctx  r2_ctx;
    bmg_pkg::t_trig r3_trig;
    bmg_pkg::t_ctx  r3_ctx;

    always_comb begin
        w_ds     = bmg_pkg::sin_div(i_idx);
        w_dc     = bmg_pkg::cos_div(i_idx);
        w_ms     = bmg_pkg::sin_rcp(i_idx);
        w_mc     = bmg_pkg::cos_rcp(i_idx);
        w_sin_on = (i_idx <= bmg_pkg::LAST_SIN_TERM);
        w_sub    = ~i_idx[0];
        // step 1: term * x^2
        w_ps = 65'(i_trig.ts) * 65'(i_trig.x2);
        w_pc = 65'(i_trig.tc) * 65'(i_trig.x2);
        // step 2: reciprocal estimate, low by at most one
        w_rs = 64'(r1_ns) * 64'(w_ms);
        w_rc = 64'(r1_nc) * 64'(w_mc);
        // step 3: one correction
        w_qds   = 32'(40'(r2_q0s) * 40'(w_ds));
        w_qdc   = 32'(40'(r2_q0c) * 40'(w_dc));
        w_rem_s = r2_ns - w_qds;
        w_rem_c = r2_nc - w_qdc;
        w_qs    = r2_q0s + 32'(w_rem_s >= 32'(w_ds));
        w_qc    = r2_q0c + 32'(w_rem_c >= 32'(w_dc));
        n_trig    = r2_trig;
        n_trig.tc = {1'b0, w_qc};
        n_trig.acc_c = w_sub ? r2_trig.acc_c - {1'b0, w_qc} : r2_trig.acc_c + {1'b0, w_qc};
        if (w_sin_on) begin
            n_trig.ts    = {1'b0, w_qs};
            n_trig.acc_s = w_sub ? r2_trig.acc_s - {1'b0, w_qs}
                                 : r2_trig.acc_s + {1'b0, w_qs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctx.vld <= 1'b0;
            r2_ctx.vld <= 1'b0;
            r3_ctx.vld <= 1'b0;
        end else if (i_en) begin
            r1_ctx <= i_ctx;
            r2_ctx <= r1_ctx;
            r3_ctx <= r2_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ns   <= w_ps[63:32];
            r1_nc   <= w_pc[63:32];
            r1_trig <= i_trig;
            r2_q0s  <= w_rs[63:32];
            r2_q0c  <= w_rc[63:32];
            r2_ns   <= r1_ns;
            r2_nc   <= r1_nc;
            r2_trig <= r1_trig;
            r3_trig <= n_trig;
        end
    end

    assign o_ctx  = r3_ctx;
    assign o_trig = r3_trig;

endmodule

/* sim/box_muller_gaussian_tb.sv */
// Self-checking testbench for the Box-Muller Gaussian generator.
`timescale 1ns / 1ps
module box_muller_gaussian_tb;

    // ------------------------------------------------------------------
    // Expected sample record and scoreboard
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [31:0] sample;
        logic        last;
        logic        saturated;
    } t_sample;

    class sample_board;
        t_sample pending[$];
        logic [31:0] mean_reg;
        logic [31:0] var_reg;
        int unsigned mismatches;
        int unsigned checked;

        function new();
            mean_reg = 32'd0;
            var_reg = 32'd65536;
            mismatches = 0;
            checked = 0;
        endfunction

        function automatic logic [63:0] isqrt(input logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic logic [63:0] radius(input logic [63:0] c1);
            int unsigned e;
            logic [63:0] t;
            logic [63:0] m;
            logic [63:0] f;
            logic [63:0] lg;
            logic [63:0] xv;
            e = 0;
            t = c1;
            while (t > 1) begin
                t = t >> 1;
                e++;
            end
            m = (e >= 31) ? (c1 >> (e - 31)) : (c1 << (31 - e));
            f = 0;
            // fractional log2 by repeated squaring
            for (int i = 0; i < 32; i++) begin
                m = (m * m) >> 31;
                f = f << 1;
                if (m >= 64'h1_0000_0000) begin
                    m = m >> 1;
                    f[0] = 1'b1;
                end
            end
            lg = (64'(bmg_pkg::UNIFORM_BITS - e) << 32) - f;
            xv = (lg >> 32) * 64'(bmg_pkg::TWO_LN2_Q30) * 4
                + (((lg & 64'hFFFF_FFFF) * 64'(bmg_pkg::TWO_LN2_Q30)) >> 30);
            return isqrt(xv << 16);
        endfunction

        function automatic t_sample scale(input logic [63:0] rv, input logic [63:0] sv,
                                          input logic [63:0] trig, input logic neg,
                                          input logic lst);
            logic [63:0] g;
            logic [63:0] mag;
            longint v;
            t_sample o;
            g = (rv * trig) >> 32;
            mag = (g * sv + (64'd1 << 31)) >> 32;
            v = longint'($signed(mean_reg));
            v = neg ? v - longint'(mag) : v + longint'(mag);
            o.saturated = 1'b0;
            if (v > 64'sd2147483647) begin
                v = 64'sd2147483647;
                o.saturated = 1'b1;
            end else if (v < -64'sd2147483648) begin
                v = -64'sd2147483648;
                o.saturated = 1'b1;
            end
            o.sample = v[31:0];
            o.last = lst;
            return o;
        endfunction

        // note an accepted input item: queue both predicted samples
        function void note_pair(input logic [31:0] u1, input logic [31:0] u2);
            logic [63:0] c1, rv, sv, p, r, a, x, x2, t, sn, cs, cv, tv;
            logic [2:0] q;
            logic cneg, sneg;
            c1 = 64'(u1 & bmg_pkg::UNIFORM_MASK);
            if (c1 == 0) c1 = 1;  // zero radius code clamps to one
            rv = radius(c1);
            sv = isqrt(64'(var_reg) << 32);
            p = 64'(u2 & bmg_pkg::UNIFORM_MASK);
            p = ((p << bmg_pkg::PHASE_UP) >> bmg_pkg::PHASE_DOWN) & 64'hFFFF_FFFF;
            q = p[31:29];
            r = p & 64'h1FFF_FFFF;
            a = q[0] ? (64'd1 << 29) - r : r;
            x = (a * 64'(bmg_pkg::PI_Q30)) >> 29;
            x2 = (x * x) >> 32;
            t = x;
            sn = x;
            for (int n = 1; n <= 5; n++) begin
                t = ((t * x2) >> 32) / 64'((2 * n) * (2 * n + 1));
                sn = (n & 1) ? sn - t : sn + t;
            end
            t = 64'h1_0000_0000;
            cs = t;
            for (int n = 1; n <= 6; n++) begin
                t = ((t * x2) >> 32) / 64'((2 * n - 1) * (2 * n));
                cs = (n & 1) ? cs - t : cs + t;
            end
            // octant mapping
            if (q == 3'd1 || q == 3'd2 || q == 3'd5 || q == 3'd6) begin
                cv = sn;
                tv = cs;
            end else begin
                cv = cs;
                tv = sn;
            end
            cneg = (q >= 3'd2 && q <= 3'd5);
            sneg = (q >= 3'd4);
            pending.push_back(scale(rv, sv, cv, cneg, 1'b0));
            pending.push_back(scale(rv, sv, tv, sneg, 1'b1));
        endfunction

        function void check_sample(input t_sample got);
            t_sample exp_s;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected sample %h last %b sat %b",
                             got.sample, got.last, got.saturated);
                return;
            end
            exp_s = pending.pop_front();
            if (exp_s != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: sample exp %h/%b/%b got %h/%b/%b",
                             exp_s.sample, exp_s.last, exp_s.saturated,
                             got.sample, got.last, got.saturated);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_first_uniform = '0;
    logic [31:0] i_second_uniform = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_sample;
    logic        o_last;
    logic        o_saturated;

    localparam int LATENCY = 88;
    localparam longint CYCLE_LIMIT = 400000;

    box_muller_gaussian i_dut (.*);

    always #1 i_clk = ~i_clk;

    sample_board board = new();
    int unsigned send_idle_pct;  // sender idle chance in percent
    int unsigned recv_idle_pct;  // receiver stall chance in percent
    int unsigned items_sent;
    int unsigned cfg_writes;
    longint cycles = 0;

    // Cycle counter and timeout watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("box_muller_gaussian test failed");
            $finish;
        end
    end

    // Receiver: random stalls, check each accepted sample.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_sample('{o_sample, o_last, o_saturated});
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one item; valid stays high until accepted.
    task automatic send_pair(input logic [31:0] u1, input logic [31:0] u2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_uniform <= u1;
        i_second_uniform <= u2;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_pair(u1, u2);
        items_sent++;
    endtask

    // Wait for the pipeline to drain, then write one register.
    task automatic write_reg(input logic idx, input logic [31:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bmg_pkg::CFG_MEAN) board.mean_reg = data;
        else board.var_reg = data;
        cfg_writes++;
    endtask

    // Random uniform code, biased toward edge values now and then.
    function automatic logic [31:0] rand_code();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'(1) << $urandom_range(31);
            3: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) send_pair(rand_code(), $urandom);
    endtask

    initial begin
        items_sent = 0;
        cfg_writes = 0;
        send_idle_pct = 19;
        recv_idle_pct = 48;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default config, extremes of both codes, all octants.
        send_pair(32'd0, 32'd0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'd1, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h4000_0000);
        for (int o = 0; o < 8; o++)
            send_pair(32'h0001_0000, (32'(o) << 29) | 32'h0F00_0000);
        send_pair(32'h0000_0003, 32'h2000_0000);
        send_pair(32'h7FFF_FFFF, 32'hE000_0000);

        // Huge variance with extreme means: forces saturation both ways.
        write_reg(bmg_pkg::CFG_VARIANCE, 32'hFFFF_FFFF);
        write_reg(bmg_pkg::CFG_MEAN, 32'h7FFF_FFFF);
        send_pair(32'd0, 32'd0);
        send_pair(32'd0, 32'h8000_0000);
        write_reg(bmg_pkg::CFG_MEAN, 32'h8000_0000);
        send_pair(32'd0, 32'd0);
        send_pair(32'd0, 32'h8000_0000);
        // Zero variance: every sample equals the mean.
        write_reg(bmg_pkg::CFG_VARIANCE, 32'd0);
        send_pair(32'd5, 32'h1234_5678);
        send_pair(32'd0, 32'h9ABC_DEF0);

        // Random phases over several settings.
        write_reg(bmg_pkg::CFG_VARIANCE, 32'd65536);
        write_reg(bmg_pkg::CFG_MEAN, 32'd0);
        run_random(450);
        write_reg(bmg_pkg::CFG_VARIANCE, $urandom);
        write_reg(bmg_pkg::CFG_MEAN, $urandom);
        run_random(450);
        send_idle_pct = 48;
        recv_idle_pct = 19;
        write_reg(bmg_pkg::CFG_VARIANCE, 32'hFFFF_FFFF);
        write_reg(bmg_pkg::CFG_MEAN, 32'h7FFF_0000);
        run_random(300);
        write_reg(bmg_pkg::CFG_VARIANCE, $urandom_range(1 << 20));
        write_reg(bmg_pkg::CFG_MEAN, $urandom);
        run_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(bmg_pkg::CFG_VARIANCE, 32'd65536);
        write_reg(bmg_pkg::CFG_MEAN, 32'hFFFF_0000);
        run_random(330);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Ran %0d items, %0d samples checked, %0d register writes,",
                 items_sent, board.checked, cfg_writes);
        $display("covering saturation, zero variance and varied stall patterns.");
        if (board.mismatches == 0) begin
            $display("box_muller_gaussian test passed");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("box_muller_gaussian test failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/bmg_pkg.sv
rtl/bmg_log_cell.sv
rtl/bmg_sqrt_cell.sv
rtl/bmg_term_cell.sv
rtl/box_muller_gaussian.sv
sim/box_muller_gaussian_tb.sv
